// File: hdl/cftp_pkg.sv
// Shared types, constants and the character classifier for the CAN frame text parser.
// No dependencies; every other file refers to it by scoped names.
package cftp_pkg;

  localparam int CHAR_W   = 8;
  localparam int ID_W     = 29;
  localparam int ACC_W    = 32;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 4;
  localparam int DATA_W   = 64;
  localparam int CNT_W    = 4;
  localparam int NIB_W    = 4;

  localparam int DEF_MAX_DATA_BYTES = 8;
  localparam int DEF_MAX_ID_DIGITS  = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_HASH  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ID_LEN   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ID_HEX   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ID_RANGE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RTR      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_BYTE     = 3'd6;
  localparam logic [STATUS_W-1:0] ST_MANY     = 3'd7;

  localparam logic [CHAR_W-1:0] CH_END   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_8     = 8'h38;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_UR    = 8'h52;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LR    = 8'h72;

  localparam logic [ACC_W-1:0] ID_MAX     = 32'h1FFF_FFFF;
  localparam logic [ACC_W-1:0] STD_ID_MAX = 32'h0000_07FF;
  localparam logic [CNT_W-1:0] ID_CNT_SAT = 4'd9;

  // Classified character word passed from front to back.
  typedef struct packed {
    logic             is_end;
    logic             is_hash;
    logic             is_rtr;
    logic             is_dot;
    logic             hex_ok;
    logic             dlc_ok;
    logic [NIB_W-1:0] val;
  } cls_t;

  function automatic cls_t classify(input logic [CHAR_W-1:0] c);
    cls_t r;
    logic is_dec;
    logic is_lo;
    logic is_up;
    is_dec   = (c >= CH_0) && (c <= CH_9);
    is_lo    = (c >= CH_LA) && (c <= CH_LF);
    is_up    = (c >= CH_UA) && (c <= CH_UF);
    r.is_end  = (c == CH_END);
    r.is_hash = (c == CH_HASH);
    r.is_rtr  = (c == CH_UR) || (c == CH_LR);
    r.is_dot  = (c == CH_DOT);
    r.hex_ok  = is_dec || is_lo || is_up;
    r.dlc_ok  = (c >= CH_0) && (c <= CH_8);
    // letters a..f and A..F have low nibble 1..6, value is that plus 9
    r.val     = is_dec ? c[NIB_W-1:0] : (c[NIB_W-1:0] + 4'd9);
    return r;
  endfunction

endpackage

// File: hdl/cftp_if.sv
// Handshake channel interfaces: character words in, frame result words out.
// Depends on cftp_pkg for field widths.
interface cftp_char_if;
  logic                        valid;
  logic                        ready;
  logic [cftp_pkg::CHAR_W-1:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface cftp_frame_if;
  logic                          valid;
  logic                          ready;
  logic [cftp_pkg::STATUS_W-1:0] status;
  logic [cftp_pkg::ID_W-1:0]     can_id;
  logic                          extended;
  logic                          remote;
  logic [cftp_pkg::LEN_W-1:0]    length_code;
  logic [cftp_pkg::DATA_W-1:0]   payload_bytes;
  modport source (output valid, output status, output can_id, output extended,
                  output remote, output length_code, output payload_bytes, input ready);
  modport sink (input valid, input status, input can_id, input extended,
                input remote, input length_code, input payload_bytes, output ready);
endinterface

// File: hdl/cftp_front.sv
// Front stage: accepts character words and registers their classification.
// Depends on cftp_pkg and cftp_char_if.
module cftp_front (
  input  logic                clk,
  input  logic                rst,
  cftp_char_if.sink           char_in,
  input  logic                q_full,
  output logic                stg_valid,
  output cftp_pkg::cls_t      stg_cls
);

  logic take;

  assign take          = stg_valid && !q_full;
  assign char_in.ready = !stg_valid || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (char_in.ready) begin
      stg_valid <= char_in.valid;
    end else if (take) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      stg_cls <= cftp_pkg::classify(char_in.char_code);
    end
  end

endmodule

// File: hdl/cftp_queue.sv
// Short queue of classified words between front and back.
// Depends on cftp_pkg.
module cftp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cftp_pkg::cls_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output cftp_pkg::cls_t head_data
);

  cftp_pkg::cls_t                entries [cftp_pkg::QUEUE_DEPTH];
  logic [cftp_pkg::QPTR_W-1:0]   wr_ptr;
  logic [cftp_pkg::QPTR_W-1:0]   rd_ptr;
  logic [cftp_pkg::QPTR_W:0]     count;

  assign full       = (count == (cftp_pkg::QPTR_W+1)'(cftp_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (cftp_pkg::QPTR_W+1)'(push) - (cftp_pkg::QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (cftp_pkg::QPTR_W+1)'(cftp_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// File: hdl/cftp_back.sv
// Back end: runs the parse state machine on classified words and holds the result word.
// Depends on cftp_pkg and cftp_frame_if.
module cftp_back #(
  parameter int MAX_DATA_BYTES = cftp_pkg::DEF_MAX_DATA_BYTES,
  parameter int MAX_ID_DIGITS  = cftp_pkg::DEF_MAX_ID_DIGITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  cftp_pkg::cls_t head_data,
  output logic           pop,
  cftp_frame_if.source   frame_out
);

  localparam logic [2:0] PH_ID        = 3'd0;
  localparam logic [2:0] PH_START     = 3'd1;
  localparam logic [2:0] PH_RTR       = 3'd2;
  localparam logic [2:0] PH_RTR_DIGIT = 3'd3;
  localparam logic [2:0] PH_DATA      = 3'd4;

  localparam logic [cftp_pkg::CNT_W-1:0] MAX_BYTES_C  = cftp_pkg::CNT_W'(MAX_DATA_BYTES);
  localparam logic [cftp_pkg::CNT_W-1:0] MAX_DIGITS_C = cftp_pkg::CNT_W'(MAX_ID_DIGITS);

  logic [2:0]                      phase, phase_next;
  logic [cftp_pkg::ACC_W-1:0]      id_accum, id_accum_next;
  logic [cftp_pkg::CNT_W-1:0]      id_cnt, id_cnt_next;
  logic                            id_bad, id_bad_next;
  logic [cftp_pkg::STATUS_W-1:0]   perr, perr_next;
  logic [cftp_pkg::DATA_W-1:0]     bytes, bytes_next;
  logic [cftp_pkg::CNT_W-1:0]      bcnt, bcnt_next;
  logic [cftp_pkg::NIB_W:0]        hnib, hnib_next;
  logic                            rem, rem_next;
  logic [cftp_pkg::LEN_W-1:0]      rlen, rlen_next;

  logic                            out_valid;
  logic                            load;
  logic [2:0]                      ph;
  logic [cftp_pkg::STATUS_W-1:0]   perr_f;
  logic [cftp_pkg::STATUS_W-1:0]   st;

  assign pop  = head_valid && (!head_data.is_end || !out_valid || frame_out.ready);
  assign load = pop && head_data.is_end;

  always_comb begin
    phase_next    = phase;
    id_accum_next = id_accum;
    id_cnt_next   = id_cnt;
    id_bad_next   = id_bad;
    perr_next     = perr;
    bytes_next    = bytes;
    bcnt_next     = bcnt;
    hnib_next     = hnib;
    rem_next      = rem;
    rlen_next     = rlen;
    ph            = phase;

    if (pop && !head_data.is_end) begin
      if (phase == PH_ID) begin
        if (head_data.is_hash) begin
          phase_next = PH_START;
        end else begin
          if (head_data.hex_ok) begin
            id_accum_next = {id_accum[cftp_pkg::ACC_W-cftp_pkg::NIB_W-1:0], head_data.val};
          end else begin
            id_bad_next = 1'b1;
          end
          if (id_cnt < cftp_pkg::ID_CNT_SAT) id_cnt_next = id_cnt + 1'b1;
        end
      end else if (perr == cftp_pkg::ST_OK) begin
        if (phase == PH_START) begin
          if (head_data.is_rtr) begin
            rem_next   = 1'b1;
            phase_next = PH_RTR;
            ph         = PH_ID;   // consumed; no further action
          end else begin
            phase_next = PH_DATA;
            ph         = PH_DATA;
          end
        end
        if (ph == PH_RTR) begin
          if (head_data.dlc_ok) begin
            rlen_next  = head_data.val;
            phase_next = PH_RTR_DIGIT;
          end else begin
            perr_next = cftp_pkg::ST_RTR;
          end
        end else if (ph == PH_RTR_DIGIT) begin
          perr_next = cftp_pkg::ST_RTR;
        end else if (ph == PH_DATA) begin
          if (!hnib[cftp_pkg::NIB_W]) begin
            if (head_data.is_dot) begin
              hnib_next = hnib;
            end else if (head_data.hex_ok) begin
              hnib_next = {1'b1, head_data.val};
            end else begin
              perr_next = cftp_pkg::ST_BYTE;
            end
          end else if (!head_data.hex_ok) begin
            perr_next = cftp_pkg::ST_BYTE;
          end else if (bcnt >= MAX_BYTES_C) begin
            perr_next = cftp_pkg::ST_MANY;
          end else begin
            bytes_next[8*bcnt[2:0] +: 8] = {hnib[cftp_pkg::NIB_W-1:0], head_data.val};
            bcnt_next = bcnt + 1'b1;
            hnib_next = '0;
          end
        end
      end
    end

    // End of text: return to the idle parse state.
    if (load) begin
      phase_next    = PH_ID;
      id_accum_next = '0;
      id_cnt_next   = '0;
      id_bad_next   = 1'b0;
      perr_next     = cftp_pkg::ST_OK;
      bytes_next    = '0;
      bcnt_next     = '0;
      hnib_next     = '0;
      rem_next      = 1'b0;
      rlen_next     = '0;
    end
  end

  // Ranked final status.
  always_comb begin
    perr_f = perr;
    if (phase == PH_DATA && perr == cftp_pkg::ST_OK && hnib[cftp_pkg::NIB_W]) begin
      perr_f = cftp_pkg::ST_BYTE;
    end
    if (phase == PH_ID) begin
      st = cftp_pkg::ST_NO_HASH;
    end else if (id_cnt == '0 || id_cnt > MAX_DIGITS_C) begin
      st = cftp_pkg::ST_ID_LEN;
    end else if (id_bad) begin
      st = cftp_pkg::ST_ID_HEX;
    end else if (id_accum > cftp_pkg::ID_MAX) begin
      st = cftp_pkg::ST_ID_RANGE;
    end else begin
      st = perr_f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_ID;
      id_accum  <= '0;
      id_cnt    <= '0;
      id_bad    <= 1'b0;
      perr      <= cftp_pkg::ST_OK;
      bytes     <= '0;
      bcnt      <= '0;
      hnib      <= '0;
      rem       <= 1'b0;
      rlen      <= '0;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      id_accum  <= id_accum_next;
      id_cnt    <= id_cnt_next;
      id_bad    <= id_bad_next;
      perr      <= perr_next;
      bytes     <= bytes_next;
      bcnt      <= bcnt_next;
      hnib      <= hnib_next;
      rem       <= rem_next;
      rlen      <= rlen_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (frame_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_out.status <= st;
      if (st == cftp_pkg::ST_OK) begin
        frame_out.can_id        <= id_accum[cftp_pkg::ID_W-1:0];
        frame_out.extended      <= (id_accum > cftp_pkg::STD_ID_MAX);
        frame_out.remote        <= rem;
        frame_out.length_code   <= rem ? rlen : bcnt;
        frame_out.payload_bytes <= rem ? '0 : bytes;
      end else begin
        frame_out.can_id        <= '0;
        frame_out.extended      <= 1'b0;
        frame_out.remote        <= 1'b0;
        frame_out.length_code   <= '0;
        frame_out.payload_bytes <= '0;
      end
    end
  end

  assign frame_out.valid = out_valid;

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    load |=> (phase == PH_ID) && (bcnt == '0) && (perr == cftp_pkg::ST_OK))
    else $error("parse state not cleared after end of text");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_out.status != cftp_pkg::ST_OK) |->
      (frame_out.can_id == '0) && (frame_out.length_code == '0) &&
      (frame_out.payload_bytes == '0) && !frame_out.remote && !frame_out.extended)
    else $error("error result carries nonzero fields");

  a_remote_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_out.remote |-> (frame_out.payload_bytes == '0))
    else $error("remote frame with data bytes");

  a_bcnt_bound: assert property (@(posedge clk) disable iff (rst)
    bcnt <= MAX_BYTES_C)
    else $error("byte count beyond limit");

endmodule

// File: hdl/can_frame_text_parser_unit.sv
// Top level of the CAN frame text parser: front stage, word queue and back end.
// Depends on cftp_pkg, cftp_if, cftp_front, cftp_queue and cftp_back.

// Takes frame text "<hexid>#<payload>" one character word per cycle and, for each
// zero character, gives one result word with status, identifier, extended and remote
// flags, length code and up to eight data bytes (first byte in bits 7:0); on any error
// only the status is nonzero. Sustained rate is one character per clock while the queue
// has room, set by the state update in the back end. A result passes through the front
// register, a queue entry and the result register after its zero character is accepted.
// Input keeps flowing while a result waits: the four-word queue absorbs the wait, and
// the back end stalls only on a zero character while the previous result is untaken.
module can_frame_text_parser_unit #(
  parameter int MAX_DATA_BYTES = cftp_pkg::DEF_MAX_DATA_BYTES,
  parameter int MAX_ID_DIGITS  = cftp_pkg::DEF_MAX_ID_DIGITS
) (
  input  logic          clk,
  input  logic          rst,
  cftp_char_if.sink     char_in,
  cftp_frame_if.source  frame_out
);

  logic           q_full;
  logic           stg_valid;
  cftp_pkg::cls_t stg_cls;
  logic           q_push;
  logic           q_pop;
  logic           head_valid;
  cftp_pkg::cls_t head_data;

  assign q_push = stg_valid && !q_full;

  cftp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .q_full    (q_full),
    .stg_valid (stg_valid),
    .stg_cls   (stg_cls)
  );

  cftp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (stg_cls),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  cftp_back #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES),
    .MAX_ID_DIGITS  (MAX_ID_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (q_pop),
    .frame_out  (frame_out)
  );

endmodule
